@@ rtl/core/pgd_pkg.sv @@
// ============================================================================
// pgd_pkg
// Shared types, constants and helpers for the g protocol packet deframer.
// ============================================================================
package pgd_pkg;

    // Largest data block the deframer accepts, in bytes
    localparam int unsigned MAX_PACKET_BYTES = 4096;

    // Field widths
    localparam int unsigned LEN_W = 13;
    localparam int unsigned IDX_W = $clog2(MAX_PACKET_BYTES);
    localparam int unsigned PAD_W = 14;

    // Line protocol constants
    localparam logic [6:0]       SYNC_CODE      = 7'h10;
    localparam logic [7:0]       CTL_CODE       = 8'd9;
    localparam logic [15:0]      CHK_MAGIC      = 16'haaaa;
    localparam logic [PAD_W-1:0] PAD_MAX        = 14'h3fff;
    localparam logic [3:0]       MAX_CODE_RESET = 4'd8;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HDR,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_CONTROL  = 3'd1,
        KIND_GOOD     = 3'd2,
        KIND_CSUM_ERR = 3'd3,
        KIND_BAD_HDR  = 3'd4,
        KIND_SIZE_ERR = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data_byte;
        logic [2:0]       ctl_type;
        logic [2:0]       ack_seq;
        logic [2:0]       send_seq;
        logic [LEN_W-1:0] payload_len;
        logic             last;
    } t_result;

    // Up to two results per received word; res1 is used only with res0
    typedef struct packed {
        logic    we0;
        logic    we1;
        t_result res0;
        t_result res1;
    } t_push;

    typedef struct packed {
        logic room2;
        logic nonempty;
    } t_q_status;

    // Block size for size code k: 16 << k
    function automatic logic [19:0] block_total(input logic [3:0] k);
        return 20'd16 << k;
    endfunction

endpackage

@@ rtl/core/pgd_if.sv @@
// ============================================================================
// pgd_if
// Valid/ready channels of the deframer: received bytes, config, results.
// ============================================================================
interface pgd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pgd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] max_size_code;

    modport source (output valid, output max_size_code, input ready);
    modport sink   (input valid, input max_size_code, output ready);
endinterface

interface pgd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  ctl_type;
    logic [2:0]  ack_seq;
    logic [2:0]  send_seq;
    logic [12:0] payload_len;
    logic        last;

    modport source (output valid, output kind, output data_byte, output ctl_type,
                    output ack_seq, output send_seq, output payload_len,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input ctl_type,
                    input ack_seq, input send_seq, input payload_len,
                    input last, output ready);
endinterface

@@ rtl/core/pgd_front.sv @@
// ============================================================================
// pgd_front
// Sync hunt, header check, g checksum and short-count stripping. Classifies
// each received word and pushes zero, one or two results into the queue.
// ============================================================================
module pgd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pgd_byte_if.sink           i_in,
    pgd_cfg_if.sink            i_cfg,
    input  pgd_pkg::t_q_status i_qstat,
    output pgd_pkg::t_push     o_push
);

    pgd_pkg::t_phase                r_phase, n_phase;
    logic [pgd_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [3:0]                     r_max;
    logic [7:0]                     r_hdr [4];
    logic [pgd_pkg::LEN_W-1:0]      r_total;
    logic [pgd_pkg::LEN_W-1:0]      r_wt;
    logic [15:0]                    r_sum_a;
    logic [15:0]                    r_sum_b;
    logic [15:0]                    r_expect;
    logic [pgd_pkg::PAD_W-1:0]      r_pad;
    logic [1:0]                     r_prefix;

    logic                           accept;
    logic [7:0]                     b;
    logic [7:0]                     hdr_x;
    logic [7:0]                     hdr_k;
    logic                           hdr_last;
    logic [19:0]                    size_total;
    logic                           hdr_bad;
    logic                           hdr_ctl;
    logic                           hdr_size;
    logic                           hdr_ok;
    logic [15:0]                    a_rot;
    logic [15:0]                    a_add;
    logic [15:0]                    b_new;
    logic [15:0]                    a_new;
    logic                           is_short;
    logic [pgd_pkg::PAD_W:0]        pad_sum;
    logic [pgd_pkg::PAD_W-1:0]      pad_max_sel;
    logic [pgd_pkg::LEN_W-1:0]      plen;
    logic [pgd_pkg::LEN_W-1:0]      idx_ext;
    logic [pgd_pkg::LEN_W-1:0]      prefix_ext;
    logic                           is_payload;
    logic                           pkt_end;
    pgd_pkg::t_result               pay;
    pgd_pkg::t_result               stat;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = i_qstat.room2;
    assign i_cfg.ready = 1'b1;
    assign b           = i_in.rx_byte;

    // Header check on the fifth header word
    assign hdr_x      = r_hdr[0] ^ r_hdr[1] ^ r_hdr[2] ^ r_hdr[3] ^ b;
    assign hdr_k      = r_hdr[0];
    assign hdr_last   = (r_idx == pgd_pkg::IDX_W'(4));
    assign size_total = pgd_pkg::block_total(hdr_k[3:0]);
    assign hdr_bad    = (hdr_x != 8'h00) ||
                        ((hdr_k != pgd_pkg::CTL_CODE) && (hdr_k > {4'h0, r_max}));
    assign hdr_ctl    = (hdr_x == 8'h00) && (hdr_k == pgd_pkg::CTL_CODE);
    assign hdr_size   = !hdr_bad && !hdr_ctl &&
                        (size_total > 20'(pgd_pkg::MAX_PACKET_BYTES));
    assign hdr_ok     = !hdr_bad && !hdr_ctl && !hdr_size;

    // Rotating g checksum step; r_wt counts the weight down from the block size
    assign a_rot = {r_sum_a[14:0], r_sum_a[15]};
    assign a_add = a_rot + {8'h00, b};
    assign b_new = r_sum_b + (a_add ^ 16'(r_wt));
    assign a_new = (a_add <= a_rot) ? (a_add ^ b_new) : a_add;

    // Short count: second prefix word adds the high bits, saturate
    assign is_short = r_hdr[3][6];
    assign pad_sum  = {1'b0, r_pad} + {b, 7'b0};

    // Payload length from the settled pad count and prefix length
    assign pad_max_sel = (r_pad > pgd_pkg::PAD_W'(r_prefix)) ? r_pad
                                                             : pgd_pkg::PAD_W'(r_prefix);
    assign plen        = (r_pad >= pgd_pkg::PAD_W'(r_total)) ? '0
                         : r_total - pad_max_sel[pgd_pkg::LEN_W-1:0];
    assign idx_ext     = pgd_pkg::LEN_W'(r_idx);
    assign prefix_ext  = pgd_pkg::LEN_W'(r_prefix);
    assign is_payload  = !(is_short && (r_idx == '0)) && (idx_ext >= prefix_ext) &&
                         ((idx_ext - prefix_ext) < plen);
    assign pkt_end     = (r_wt == pgd_pkg::LEN_W'(1));

    // Next phase and word index
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (accept) begin
            case (r_phase)
                pgd_pkg::PH_HUNT: begin
                    if (b[6:0] == pgd_pkg::SYNC_CODE) begin
                        n_phase = pgd_pkg::PH_HDR;
                        n_idx   = '0;
                    end
                end
                pgd_pkg::PH_HDR: begin
                    if (hdr_last) begin
                        n_idx   = '0;
                        n_phase = hdr_ok ? pgd_pkg::PH_DATA : pgd_pkg::PH_HUNT;
                    end else begin
                        n_idx = r_idx + pgd_pkg::IDX_W'(1);
                    end
                end
                pgd_pkg::PH_DATA: begin
                    if (pkt_end) begin
                        n_idx   = '0;
                        n_phase = pgd_pkg::PH_HUNT;
                    end else begin
                        n_idx = r_idx + pgd_pkg::IDX_W'(1);
                    end
                end
                default: begin
                    n_phase = pgd_pkg::PH_HUNT;
                    n_idx   = '0;
                end
            endcase
        end
    end

    // Build results for the queue
    always_comb begin
        o_push = '0;
        pay    = '0;
        stat   = '0;

        pay.kind        = pgd_pkg::KIND_PAYLOAD;
        pay.data_byte   = b;
        pay.ack_seq     = r_hdr[3][2:0];
        pay.send_seq    = r_hdr[3][5:3];
        pay.payload_len = plen;
        pay.last        = 1'b0;

        stat.last = 1'b1;
        case (r_phase)
            pgd_pkg::PH_HDR: begin
                if (hdr_ctl) begin
                    stat.kind     = pgd_pkg::KIND_CONTROL;
                    stat.ctl_type = r_hdr[3][5:3];
                    stat.ack_seq  = r_hdr[3][2:0];
                end else if (hdr_bad) begin
                    stat.kind = pgd_pkg::KIND_BAD_HDR;
                end else begin
                    stat.kind = pgd_pkg::KIND_SIZE_ERR;
                end
                o_push.res0 = stat;
                o_push.we0  = accept && hdr_last && !hdr_ok;
            end
            pgd_pkg::PH_DATA: begin
                stat.kind        = (a_new == r_expect) ? pgd_pkg::KIND_GOOD
                                                       : pgd_pkg::KIND_CSUM_ERR;
                stat.ack_seq     = r_hdr[3][2:0];
                stat.send_seq    = r_hdr[3][5:3];
                stat.payload_len = plen;
                if (is_payload) begin
                    o_push.res0 = pay;
                    o_push.res1 = stat;
                    o_push.we0  = accept;
                    o_push.we1  = accept && pkt_end;
                end else begin
                    o_push.res0 = stat;
                    o_push.we0  = accept && pkt_end;
                end
            end
            default: begin
                o_push.we0 = 1'b0;
            end
        endcase
    end

    // Control state and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pgd_pkg::PH_HUNT;
            r_idx   <= '0;
            r_max   <= pgd_pkg::MAX_CODE_RESET;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.max_size_code;
            end
        end
    end

    // Header words, checksum and short-count datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            case (r_phase)
                pgd_pkg::PH_HDR: begin
                    if (!hdr_last) begin
                        r_hdr[r_idx[1:0]] <= b;
                    end else begin
                        // Arm the data block
                        r_total  <= size_total[pgd_pkg::LEN_W-1:0];
                        r_wt     <= size_total[pgd_pkg::LEN_W-1:0];
                        r_sum_a  <= 16'hffff;
                        r_sum_b  <= 16'h0000;
                        r_pad    <= '0;
                        r_prefix <= 2'd0;
                        r_expect <= (pgd_pkg::CHK_MAGIC - {r_hdr[2], r_hdr[1]}) ^
                                    {8'h00, r_hdr[3] | 8'h80};
                    end
                end
                pgd_pkg::PH_DATA: begin
                    r_sum_a <= a_new;
                    r_sum_b <= b_new;
                    r_wt    <= r_wt - pgd_pkg::LEN_W'(1);
                    if (is_short && (r_idx == '0)) begin
                        if (b[7]) begin
                            r_prefix <= 2'd2;
                            r_pad    <= pgd_pkg::PAD_W'(b[6:0]);
                        end else begin
                            r_prefix <= 2'd1;
                            r_pad    <= pgd_pkg::PAD_W'(b);
                        end
                    end else if (is_short && (r_idx == pgd_pkg::IDX_W'(1)) &&
                                 (r_prefix == 2'd2)) begin
                        r_pad <= (pad_sum > {1'b0, pgd_pkg::PAD_MAX}) ? pgd_pkg::PAD_MAX
                                 : pad_sum[pgd_pkg::PAD_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/pgd_queue.sv @@
// ============================================================================
// pgd_queue
// Short result queue between front and back; takes up to two results a
// cycle and gives one.
// ============================================================================
module pgd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pgd_pkg::t_push     i_push,
    input  logic               i_pop,
    output pgd_pkg::t_result   o_head,
    output pgd_pkg::t_q_status o_qstat
);

    pgd_pkg::t_result           r_mem [pgd_pkg::QUEUE_DEPTH];
    logic [pgd_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [pgd_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [pgd_pkg::QCNT_W-1:0] r_count, n_count;
    logic [pgd_pkg::QPTR_W-1:0] wr_ptr1;

    assign wr_ptr1 = r_wr_ptr + pgd_pkg::QPTR_W'(1);

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.we0 && i_push.we1) begin
            n_wr_ptr = r_wr_ptr + pgd_pkg::QPTR_W'(2);
        end else if (i_push.we0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_rd_ptr = i_pop ? r_rd_ptr + pgd_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + pgd_pkg::QCNT_W'(i_push.we0) + pgd_pkg::QCNT_W'(i_push.we1)
                   - pgd_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push.we0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.we0 && i_push.we1) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_qstat.nonempty = (r_count != '0);
    assign o_qstat.room2    = (r_count <= pgd_pkg::QCNT_W'(pgd_pkg::QUEUE_DEPTH - 2));

endmodule

@@ rtl/core/pgd_back.sv @@
// ============================================================================
// pgd_back
// Drains the result queue into the output register and drives the result
// channel.
// ============================================================================
module pgd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pgd_pkg::t_result   i_head,
    input  pgd_pkg::t_q_status i_qstat,
    output logic               o_pop,
    pgd_result_if.source       o_out
);

    logic             r_valid, n_valid;
    pgd_pkg::t_result r_res;

    // Pop when the output register is free or being taken
    assign o_pop = i_qstat.nonempty && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_res.kind;
    assign o_out.data_byte   = r_res.data_byte;
    assign o_out.ctl_type    = r_res.ctl_type;
    assign o_out.ack_seq     = r_res.ack_seq;
    assign o_out.send_seq    = r_res.send_seq;
    assign o_out.payload_len = r_res.payload_len;
    assign o_out.last        = r_res.last;

endmodule

@@ rtl/core/g_protocol_packet_deframer_top.sv @@
// Receive deframer for the g line protocol. It takes one line byte per cycle
// on i_in and hunts for sync, checks the five-byte header, runs the rotating
// g checksum over the data block, strips the short count and streams payload
// bytes on o_out, ending each packet with one status word (last = 1). A byte
// is classified in the cycle it is accepted; its results enter a four-entry
// queue and reach o_out through an output register. The front takes a byte
// whenever the queue has room for two results, so with o_out ready it
// sustains one byte per cycle; the final byte of a packet can yield a
// payload word and the status word, which the queue absorbs. The user must
// write the max_size_code register on i_cfg only while idle; the block
// does not enforce it. No clearing pass follows reset.
// ============================================================================
// g_protocol_packet_deframer_top
// Top level: front classifier, result queue and output stage.
// ============================================================================
module g_protocol_packet_deframer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pgd_byte_if.sink     i_in,
    pgd_cfg_if.sink      i_cfg,
    pgd_result_if.source o_out
);

    pgd_pkg::t_push     w_push;
    pgd_pkg::t_q_status w_qstat;
    pgd_pkg::t_result   w_head;
    logic               w_pop;

    pgd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push)
    );

    pgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    pgd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // Front never writes past the queue's free space
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.we0 |-> w_qstat.room2)
        else $error("result pushed without room in queue");

    // Second slot is only used together with the first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.we1 |-> w_push.we0)
        else $error("second result pushed without first");

    // While the queue holds a result, the output is valid in the next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.nonempty |=> o_out.valid)
        else $error("queued result not presented");

    // Payload words never close a packet
    a_payload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == pgd_pkg::KIND_PAYLOAD)) |-> !o_out.last)
        else $error("payload word marked last");

endmodule
